// ===== hdl/wtw_pkg.sv =====
// shared types, constants and helpers of the windowed task watchdog
package wtw_pkg;

    localparam int CNT_W = 16;

    typedef enum logic [1:0] {
        REG_LOW_WINDOW   = 2'd0,
        REG_HIGH_WINDOW  = 2'd1,
        REG_CHECK_PERIOD = 2'd2,
        REG_TICK_MS      = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        CAUSE_NONE       = 2'd0,
        CAUSE_ILLEGAL_ID = 2'd1,
        CAUSE_WINDOW     = 2'd2
    } fault_cause_t;

    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [CNT_W-1:0] LOW_WINDOW_RST   = 16'd700;
    localparam logic [CNT_W-1:0] HIGH_WINDOW_RST  = 16'd1000;
    localparam logic [CNT_W-1:0] CHECK_PERIOD_RST = 16'd800;
    localparam logic [CNT_W-1:0] TICK_MS_RST      = 16'd20;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_SCAN = 2'd2,
        ST_DONE = 2'd3
    } state_t;

    typedef struct packed {
        logic load_in;
        logic add_op;
        logic raise_illegal;
        logic raise_window;
        logic scan_sel;
        logic idx_clr;
        logic idx_inc;
        logic clear_all;
        logic set_kick;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic fault;
        logic is_tick;
        logic self_bad;
        logic id_bad;
        logic period_over;
        logic scan_bad;
        logic scan_last;
        logic out_free;
    } status_t;

    function automatic logic [CNT_W-1:0] sat_add16(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// ===== hdl/windowed_task_watchdog.sv =====
// top level of the windowed task watchdog
//
//  channel  | group     | payload
//  ---------+-----------+------------------------------------------------
//  request  | s_axis_*  | tuser: command; tdata: task_id, amount_ms
//  result   | m_axis_*  | tdata: kick, fault, fault_cause, fault_task
//  config   | cfg_*     | cfg_addr selects register, cfg_wdata 16 bits
//
// a report or a tick without a check runs idle, exec and done; done loads the output register
// a tick that triggers a check also runs the scan state, which walks one counter a cycle up to the first bad one
// one request in flight; the next is accepted while the result waits in the output register
// reset clears all counters and the fault latch, registers return to defaults
// while a result is stalled the next result waits in the done state until the stalled one is taken
module windowed_task_watchdog #(
    parameter int NUM_TASKS = 8,
    parameter int SELF_TASK = 0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // task_id[3:0], amount_ms[19:4], zero pad
    input  logic [0:0]  s_axis_tuser,   // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // kick[0], fault[1], fault_cause[3:2], fault_task[7:4]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    wtw_pkg::cmd_t    cmd;
    wtw_pkg::status_t st;

    logic       kick;
    logic       fault;
    logic [1:0] fault_cause;
    logic [3:0] fault_task;

    wtw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    wtw_datapath #(
        .NUM_TASKS (NUM_TASKS),
        .SELF_TASK (SELF_TASK)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .in_command      (s_axis_tuser[0]),
        .in_task_id      (s_axis_tdata[3:0]),
        .in_amount_ms    (s_axis_tdata[19:4]),
        .cmd             (cmd),
        .st              (st),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_kick        (kick),
        .out_fault       (fault),
        .out_fault_cause (fault_cause),
        .out_fault_task  (fault_task)
    );

    assign m_axis_tdata = {fault_task, fault_cause, fault, kick};

endmodule

// ===== hdl/wtw_ctrl.sv =====
// controller state machine of the windowed task watchdog
module wtw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wtw_pkg::status_t  st,
    output wtw_pkg::cmd_t     cmd
);

    wtw_pkg::state_t state_reg;
    wtw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wtw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            wtw_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = wtw_pkg::ST_EXEC;
                end
            end
            wtw_pkg::ST_EXEC:
            begin
                state_next = wtw_pkg::ST_DONE;
                if (!st.fault)
                begin
                    if (st.is_tick)
                    begin
                        if (st.self_bad)
                        begin
                            cmd.raise_illegal = 1'b1;
                        end
                        else
                        begin
                            cmd.add_op = 1'b1;
                            if (st.period_over)
                            begin
                                cmd.idx_clr = 1'b1;
                                state_next  = wtw_pkg::ST_SCAN;
                            end
                            else
                            begin
                                cmd.set_kick = 1'b1;
                            end
                        end
                    end
                    else if (st.id_bad)
                    begin
                        cmd.raise_illegal = 1'b1;
                    end
                    else
                    begin
                        cmd.add_op = 1'b1;
                    end
                end
            end
            wtw_pkg::ST_SCAN:
            begin
                cmd.scan_sel = 1'b1;
                if (st.scan_bad)
                begin
                    cmd.raise_window = 1'b1;
                    state_next       = wtw_pkg::ST_DONE;
                end
                else if (st.scan_last)
                begin
                    cmd.clear_all = 1'b1;
                    cmd.set_kick  = 1'b1;
                    state_next    = wtw_pkg::ST_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            wtw_pkg::ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = wtw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wtw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/wtw_datapath.sv =====
// counters, fault latch, configuration registers and output register
module wtw_datapath #(
    parameter int NUM_TASKS = 8,
    parameter int SELF_TASK = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [15:0]       cfg_wdata,
    input  logic              in_command,
    input  logic [3:0]        in_task_id,
    input  logic [15:0]       in_amount_ms,
    input  wtw_pkg::cmd_t     cmd,
    output wtw_pkg::status_t  st,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_kick,
    output logic              out_fault,
    output logic [1:0]        out_fault_cause,
    output logic [3:0]        out_fault_task
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam logic [IDX_W-1:0] SELF_IDX  = IDX_W'(SELF_TASK % NUM_TASKS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_TASKS - 1);
    localparam logic             SELF_BAD  = (SELF_TASK >= NUM_TASKS);
    localparam logic [4:0]       NUM_LIMIT = 5'(NUM_TASKS);

    logic [15:0] low_window_reg;
    logic [15:0] high_window_reg;
    logic [15:0] check_period_reg;
    logic [15:0] tick_ms_reg;

    logic        command_reg;
    logic [3:0]  task_id_reg;
    logic [15:0] amount_reg;

    logic [15:0] counts_reg [NUM_TASKS];
    logic [15:0] period_reg;
    logic [15:0] period_next;
    logic [IDX_W-1:0] idx_reg;

    logic        fault_reg;
    logic [1:0]  cause_reg;
    logic [3:0]  ftask_reg;
    logic        kick_reg;

    logic        out_valid_reg;
    logic        out_kick_reg;
    logic        out_fault_reg;
    logic [1:0]  out_cause_reg;
    logic [3:0]  out_task_reg;

    logic [IDX_W-1:0] id_idx;
    logic [IDX_W-1:0] rd_addr;
    logic [15:0]      rd_data;
    logic [15:0]      addend;
    logic [15:0]      sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_window_reg   <= wtw_pkg::LOW_WINDOW_RST;
            high_window_reg  <= wtw_pkg::HIGH_WINDOW_RST;
            check_period_reg <= wtw_pkg::CHECK_PERIOD_RST;
            tick_ms_reg      <= wtw_pkg::TICK_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                wtw_pkg::REG_LOW_WINDOW:   low_window_reg   <= cfg_wdata;
                wtw_pkg::REG_HIGH_WINDOW:  high_window_reg  <= cfg_wdata;
                wtw_pkg::REG_CHECK_PERIOD: check_period_reg <= cfg_wdata;
                wtw_pkg::REG_TICK_MS:      tick_ms_reg      <= cfg_wdata;
                default:                   ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            command_reg <= in_command;
            task_id_reg <= in_task_id;
            amount_reg  <= in_amount_ms;
        end
    end

    assign id_idx  = task_id_reg[IDX_W-1:0];
    assign rd_addr = cmd.scan_sel ? idx_reg :
                     ((command_reg == wtw_pkg::CMD_TICK) ? SELF_IDX : id_idx);
    assign rd_data = counts_reg[rd_addr];
    assign addend  = (command_reg == wtw_pkg::CMD_TICK) ? tick_ms_reg : amount_reg;
    assign sum     = wtw_pkg::sat_add16(rd_data, addend);
    assign period_next = wtw_pkg::sat_add16(period_reg, tick_ms_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                counts_reg[i] <= '0;
            end
            period_reg <= '0;
        end
        else if (cmd.clear_all)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                counts_reg[i] <= '0;
            end
            period_reg <= '0;
        end
        else if (cmd.add_op)
        begin
            counts_reg[rd_addr] <= sum;
            if (command_reg == wtw_pkg::CMD_TICK)
            begin
                period_reg <= period_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            fault_reg <= 1'b0;
            cause_reg <= wtw_pkg::CAUSE_NONE;
            ftask_reg <= '0;
            kick_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.load_in)
            begin
                kick_reg <= 1'b0;
            end
            else if (cmd.set_kick)
            begin
                kick_reg <= 1'b1;
            end
            if (cmd.raise_illegal)
            begin
                fault_reg <= 1'b1;
                cause_reg <= wtw_pkg::CAUSE_ILLEGAL_ID;
                ftask_reg <= (command_reg == wtw_pkg::CMD_TICK) ? 4'(SELF_TASK)
                                                                : task_id_reg;
            end
            else if (cmd.raise_window)
            begin
                fault_reg <= 1'b1;
                cause_reg <= wtw_pkg::CAUSE_WINDOW;
                ftask_reg <= 4'(idx_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_kick_reg  <= kick_reg;
            out_fault_reg <= fault_reg;
            out_cause_reg <= cause_reg;
            out_task_reg  <= ftask_reg;
        end
    end

    always_comb
    begin
        st             = '0;
        st.fault       = fault_reg;
        st.is_tick     = (command_reg == wtw_pkg::CMD_TICK);
        st.self_bad    = SELF_BAD;
        st.id_bad      = ({1'b0, task_id_reg} >= NUM_LIMIT);
        st.period_over = (period_next > check_period_reg);
        st.scan_bad    = (rd_data < low_window_reg) || (rd_data > high_window_reg);
        st.scan_last   = (idx_reg == LAST_IDX);
        st.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign out_kick        = out_kick_reg;
    assign out_fault       = out_fault_reg;
    assign out_fault_cause = out_cause_reg;
    assign out_fault_task  = out_task_reg;

endmodule

// ===== hdl/wtw_checker.sv =====
// port-level checks of the windowed task watchdog
module wtw_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata
);

    logic seen_fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_fault_reg <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[1])
        begin
            seen_fault_reg <= 1'b1;
        end
    end

    a_kick_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1])
        else $error("kick with fault set");

    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && seen_fault_reg |-> m_axis_tdata[1] && !m_axis_tdata[0])
        else $error("fault cleared after latching");

    a_no_fault_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[7:2] == 6'd0)
        else $error("fault fields set without fault");

    a_fault_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |->
            (m_axis_tdata[3:2] == wtw_pkg::CAUSE_ILLEGAL_ID) ||
            (m_axis_tdata[3:2] == wtw_pkg::CAUSE_WINDOW))
        else $error("fault without valid cause");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

endmodule

bind windowed_task_watchdog wtw_checker u_wtw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
